// ===== rtl/core/cpbs_pkg.sv =====
package cpbs_pkg;

	// address width actually kept, low bits of byte_address
	localparam int ADDR_BITS = 64;
	localparam logic [63:0] ADDR_MASK =
		(ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);

	// lookahead window
	localparam int WIN_DEPTH = 6;
	localparam int CNT_W = $clog2(WIN_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_DEPTH);
	localparam logic [CNT_W-1:0] CNT_NEAR = CNT_W'(WIN_DEPTH - 1);
	localparam logic [1:0] SKIP_AFTER_MATCH = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_PUSH_FRAME = 2'd0;
	localparam logic [1:0] CFG_STACK_SUB = 2'd1;
	localparam logic [1:0] CFG_SHADOW_STORE = 2'd2;

	// opcode bytes
	localparam logic [7:0] OP_PUSH_RBP = 8'h55;
	localparam logic [7:0] OP_REX_W = 8'h48;
	localparam logic [7:0] OP_MOV = 8'h89;
	localparam logic [7:0] OP_MODRM_RBP_RSP = 8'hE5;
	localparam logic [7:0] OP_GRP1_IMM8 = 8'h83;
	localparam logic [7:0] OP_MODRM_SUB_RSP = 8'hEC;
	localparam logic [7:0] OP_GRP1_IMM32 = 8'h81;
	localparam logic [7:0] OP_MODRM_SIB_RCX = 8'h4C;
	localparam logic [7:0] OP_SIB_RSP = 8'h24;
	localparam logic [7:0] OP_PUSH_RBX = 8'h53;
	localparam logic [7:0] OP_PUSH_RSI = 8'h56;
	localparam logic [7:0] OP_PUSH_RDI = 8'h57;

	typedef struct packed {
		logic push_frame;
		logic stack_sub;
		logic shadow_store;
	} cpbs_cfg_t;

	typedef struct packed {
		logic       match;
		logic [1:0] skip;
	} cpbs_dec_t;

	function automatic logic cpbs_is_push(input logic [7:0] b);
		return (b == OP_PUSH_RBX) || (b == OP_PUSH_RBP) ||
			(b == OP_PUSH_RSI) || (b == OP_PUSH_RDI);
	endfunction

	// decide one position: suppression, known flag, then the pattern set
	function automatic cpbs_dec_t cpbs_decide(
		input logic [1:0] skip,
		input logic       known,
		input logic [7:0] b0,
		input logic [7:0] b1,
		input logic [7:0] b2,
		input logic [7:0] b3,
		input logic [3:0] a_lo,
		input cpbs_cfg_t  en,
		input logic       imm32_ok
	);
		cpbs_dec_t d;
		logic      hit;
		hit = 1'b0;
		if (en.push_frame && b0 == OP_PUSH_RBP && b1 == OP_REX_W &&
			b2 == OP_MOV && b3 == OP_MODRM_RBP_RSP)
			hit = 1'b1;
		if (en.stack_sub && b0 == OP_REX_W && b1 == OP_GRP1_IMM8 &&
			b2 == OP_MODRM_SUB_RSP)
			hit = 1'b1;
		if (en.stack_sub && imm32_ok && b0 == OP_REX_W && b1 == OP_GRP1_IMM32 &&
			b2 == OP_MODRM_SUB_RSP)
			hit = 1'b1;
		if (en.shadow_store && b0 == OP_REX_W && b1 == OP_MOV &&
			b2 == OP_MODRM_SIB_RCX && b3 == OP_SIB_RSP)
			hit = 1'b1;
		if (en.push_frame && a_lo == 4'd0 && cpbs_is_push(b0) &&
			(b1 == OP_REX_W || cpbs_is_push(b1)))
			hit = 1'b1;
		d.match = 1'b0;
		d.skip = skip;
		if (skip != 2'd0) begin
			d.skip = skip - 2'd1;
		end else if (!known && hit) begin
			d.match = 1'b1;
			d.skip = SKIP_AFTER_MATCH;
		end
		return d;
	endfunction

endpackage

// ===== rtl/core/cpbs_in_reg.sv =====
module cpbs_in_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic [63:0] in_addr,
	input  logic        in_known,
	input  logic        in_last,
	output logic        valid_s1,
	input  logic        take_s1,
	output logic [7:0]  byte_s1,
	output logic [63:0] addr_s1,
	output logic        known_s1,
	output logic        last_s1
);
	import cpbs_pkg::*;

	logic load;

	// the stage frees up in the same cycle it is taken
	assign in_ready = !valid_s1 || take_s1;
	assign load = in_valid && in_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// item payload, address cut to the kept width
	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
			addr_s1 <= in_addr & ADDR_MASK;
			known_s1 <= in_known;
			last_s1 <= in_last;
		end
	end

endmodule

// ===== rtl/core/cpbs_scan.sv =====
module cpbs_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  cpbs_pkg::cpbs_cfg_t cfg,
	input  logic              valid_s1,
	output logic              take_s1,
	input  logic [7:0]        byte_s1,
	input  logic [63:0]       addr_s1,
	input  logic              known_s1,
	input  logic              last_s1,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       out_addr
);
	import cpbs_pkg::*;

	logic [7:0]       win_q [WIN_DEPTH];
	logic             known_q [WIN_DEPTH];
	logic [63:0]      oldest_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       skip_q;
	logic             out_valid_q;
	logic [63:0]      out_addr_q;

	logic [7:0]       nw [WIN_DEPTH];
	logic             nk [WIN_DEPTH];
	logic [63:0]      nold;
	logic [63:0]      nold_p1;
	logic [CNT_W-1:0] ncnt;
	logic [1:0]       nskip;
	cpbs_dec_t        d0;
	cpbs_dec_t        d1;
	logic             found;
	logic [63:0]      hit_addr;

	assign take_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_addr = out_addr_q;

	// window after inserting the staged byte
	always_comb begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			nw[i] = win_q[i];
			nk[i] = known_q[i];
		end
		nold = oldest_q;
		ncnt = cnt_q;
		if (cnt_q == CNT_FULL) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				nw[i] = win_q[i+1];
				nk[i] = known_q[i+1];
			end
			nw[WIN_DEPTH-1] = byte_s1;
			nk[WIN_DEPTH-1] = known_s1;
			nold = (oldest_q + 64'd1) & ADDR_MASK;
		end else begin
			if (cnt_q == '0)
				nold = addr_s1;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				if (cnt_q == CNT_W'(i)) begin
					nw[i] = byte_s1;
					nk[i] = known_s1;
				end
			end
			ncnt = cnt_q + CNT_W'(1);
		end
		nold_p1 = (nold + 64'd1) & ADDR_MASK;
	end

	// decide the oldest position, and the one after it at the section end
	always_comb begin
		d0 = cpbs_decide(skip_q, nk[0], nw[0], nw[1], nw[2], nw[3], nold[3:0], cfg,
			!last_s1);
		d1 = cpbs_decide(d0.skip, nk[1], nw[1], nw[2], nw[3], nw[4], nold_p1[3:0],
			cfg, 1'b0);
		found = 1'b0;
		hit_addr = nold;
		nskip = skip_q;
		if (!last_s1) begin
			if (ncnt == CNT_FULL) begin
				found = d0.match;
				nskip = d0.skip;
			end
		end else if (ncnt == CNT_FULL) begin
			if (d0.match) begin
				found = 1'b1;
			end else if (d1.match) begin
				found = 1'b1;
				hit_addr = nold_p1;
			end
		end else if (ncnt == CNT_NEAR) begin
			found = d0.match;
		end
	end

	// window state, cleared at each section end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
				known_q[i] <= 1'b0;
			end
			oldest_q <= '0;
			cnt_q <= '0;
			skip_q <= '0;
		end else if (take_s1) begin
			if (last_s1) begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					win_q[i] <= '0;
					known_q[i] <= 1'b0;
				end
				oldest_q <= '0;
				cnt_q <= '0;
				skip_q <= '0;
			end else begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					win_q[i] <= nw[i];
					known_q[i] <= nk[i];
				end
				oldest_q <= nold;
				cnt_q <= ncnt;
				skip_q <= nskip;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1 && found) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && found)
			out_addr_q <= hit_addr & ADDR_MASK;
	end

endmodule

// ===== rtl/core/code_prologue_byte_scanner.sv =====
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------
// s_*      | in        | s_tvalid/s_tready  | tdata: code_byte, byte_address; tuser:
//          |           |                    | already_known; tlast: section_end
// m_*      | out       | m_tvalid/m_tready  | tdata: prologue_address
// cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (enable bit)
//
// one item per cycle sustained unless a pending result is stalled by m_tready; each item goes
// through the input register, then window update and pattern compare into the result register
// arst_n clears the window, the suppression count and the valid flags; all enables set
// a stalled result holds the scan stage, which fills the input register before s_tready drops
// cfg_ready is always high; writes are taken at once
module code_prologue_byte_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // [7:0] code_byte, [71:8] byte_address
	input  logic        s_tuser,  // [0] already_known
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [63:0] prologue_address
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);
	import cpbs_pkg::*;

	cpbs_cfg_t   cfg_q;
	logic        valid_s1;
	logic        take_s1;
	logic [7:0]  byte_s1;
	logic [63:0] addr_s1;
	logic        known_s1;
	logic        last_s1;

	assign cfg_ready = 1'b1;

	// enable registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{push_frame: 1'b1, stack_sub: 1'b1, shadow_store: 1'b1};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PUSH_FRAME: cfg_q.push_frame <= cfg_data;
				CFG_STACK_SUB: cfg_q.stack_sub <= cfg_data;
				CFG_SHADOW_STORE: cfg_q.shadow_store <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cpbs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata[7:0]),
		.in_addr  (s_tdata[71:8]),
		.in_known (s_tuser),
		.in_last  (s_tlast),
		.valid_s1 (valid_s1),
		.take_s1  (take_s1),
		.byte_s1  (byte_s1),
		.addr_s1  (addr_s1),
		.known_s1 (known_s1),
		.last_s1  (last_s1)
	);

	cpbs_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.take_s1   (take_s1),
		.byte_s1   (byte_s1),
		.addr_s1   (addr_s1),
		.known_s1  (known_s1),
		.last_s1   (last_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_addr  (m_tdata)
	);

endmodule

// ===== bench/code_prologue_byte_scanner_test.sv =====
module code_prologue_byte_scanner_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cpbs_pkg::*;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;  // [7:0] code_byte, [71:8] byte_address
	logic        s_tuser = 1'b0;  // [0] already_known
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // [63:0] prologue_address
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_PUSH_FRAME;
	logic        cfg_data = 1'b0;

	// scanner model state
	cpbs_cfg_t   scan_en = '1;
	logic [7:0]  win_byte [WIN_DEPTH];
	logic        win_known [WIN_DEPTH];
	logic [63:0] win_base;
	int          win_count;
	logic [1:0]  skip_left;
	logic [63:0] prologue_expected [$];

	int       fail_count = 0;
	int       burst_left = 0;
	bit       gaps_on = 1'b0;
	rx_mode_e rx_mode = RX_OPEN;
	int       rx_tick = 0;

	code_prologue_byte_scanner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stall pattern
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: m_tready <= ((rx_tick % 7) < 3);
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// compare each result item with the oldest predicted address
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (prologue_expected.size() == 0) begin
				$display("%0t: prologue_address expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = prologue_expected.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: prologue_address expected %h, actual %h",
						$time, want, m_tdata);
					fail_count++;
				end
			end
		end
	end

	function automatic void clear_scan_window();
		foreach (win_byte[i]) begin
			win_byte[i] = '0;
			win_known[i] = 1'b0;
		end
		win_base = '0;
		win_count = 0;
		skip_left = '0;
	endfunction

	function automatic logic is_push_byte(input logic [7:0] b);
		return b inside {OP_PUSH_RBX, OP_PUSH_RBP, OP_PUSH_RSI, OP_PUSH_RDI};
	endfunction

	// decide the position at window slot idx; a match starts the suppression shadow
	function automatic logic decide_position(input int idx, input logic imm32_ok,
		output logic [63:0] hit);
		logic [63:0] a;
		logic [7:0]  b0, b1, b2, b3;
		logic        m;
		a = (win_base + idx) & ADDR_MASK;
		b0 = win_byte[idx];
		b1 = win_byte[idx + 1];
		b2 = win_byte[idx + 2];
		b3 = win_byte[idx + 3];
		hit = '0;
		m = 1'b0;
		if (skip_left != 0) begin
			skip_left = skip_left - 2'd1;
			return 1'b0;
		end
		if (win_known[idx])
			return 1'b0;
		if (scan_en.push_frame &&
			{b0, b1, b2, b3} == {OP_PUSH_RBP, OP_REX_W, OP_MOV, OP_MODRM_RBP_RSP})
			m = 1'b1;
		if (scan_en.stack_sub && {b0, b1, b2} == {OP_REX_W, OP_GRP1_IMM8, OP_MODRM_SUB_RSP})
			m = 1'b1;
		if (scan_en.stack_sub && imm32_ok &&
			{b0, b1, b2} == {OP_REX_W, OP_GRP1_IMM32, OP_MODRM_SUB_RSP})
			m = 1'b1;
		if (scan_en.shadow_store &&
			{b0, b1, b2, b3} == {OP_REX_W, OP_MOV, OP_MODRM_SIB_RCX, OP_SIB_RSP})
			m = 1'b1;
		if (scan_en.push_frame && a[3:0] == 4'd0 && is_push_byte(b0) &&
			(b1 == OP_REX_W || is_push_byte(b1)))
			m = 1'b1;
		if (m) begin
			skip_left = SKIP_AFTER_MATCH;
			hit = a;
		end
		return m;
	endfunction

	// shift one accepted byte into the window and predict its result
	function automatic void scan_model_step(input logic [7:0] code, input logic [63:0] addr,
		input logic known, input logic last);
		logic [63:0] hit;
		logic        found;
		if (win_count >= WIN_DEPTH) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_byte[i] = win_byte[i + 1];
				win_known[i] = win_known[i + 1];
			end
			win_byte[WIN_DEPTH - 1] = code;
			win_known[WIN_DEPTH - 1] = known;
			win_base = (win_base + 64'd1) & ADDR_MASK;
		end else begin
			if (win_count == 0)
				win_base = addr & ADDR_MASK;
			win_byte[win_count] = code;
			win_known[win_count] = known;
			win_count++;
		end
		found = 1'b0;
		hit = '0;
		if (!last) begin
			if (win_count == WIN_DEPTH)
				found = decide_position(0, 1'b1, hit);
		end else begin
			// section end: the last two scannable positions are settled now
			if (win_count == WIN_DEPTH) begin
				found = decide_position(0, 1'b0, hit);
				if (!found)
					found = decide_position(1, 1'b0, hit);
			end else if (win_count == WIN_DEPTH - 1) begin
				found = decide_position(0, 1'b0, hit);
			end
			clear_scan_window();
		end
		if (found)
			prologue_expected.insert(prologue_expected.size(), hit & ADDR_MASK);
	endfunction

	// send one byte item, with bursts and gaps on the sender side
	task automatic send_scan_byte(input logic [7:0] code, input logic [63:0] addr,
		input logic known, input logic last);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {addr, code};
		s_tuser <= known;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		scan_model_step(code, addr, known, last);
	endtask

	task automatic send_section(input logic [7:0] code[$], input logic known[$],
		input logic [63:0] base, input logic with_end, input int jump_at);
		logic [63:0] addr;
		addr = base;
		foreach (code[i]) begin
			// an address jump inside a section is ignored by the scanner
			if (i == jump_at)
				addr = {$urandom, $urandom};
			send_scan_byte(code[i], addr, (i < known.size()) ? known[i] : 1'b0,
				with_end && (i == code.size() - 1));
			addr++;
		end
	endtask

	// drop valid and let every pending result drain, then cover the pipe latency
	task automatic wait_scan_idle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (prologue_expected.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic put_cfg_write(input logic [1:0] idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_PUSH_FRAME: scan_en.push_frame = val;
			CFG_STACK_SUB: scan_en.stack_sub = val;
			default: scan_en.shadow_store = val;
		endcase
	endtask

	task automatic set_scan_enables(input cpbs_cfg_t en);
		put_cfg_write(CFG_PUSH_FRAME, en.push_frame);
		put_cfg_write(CFG_STACK_SUB, en.stack_sub);
		put_cfg_write(CFG_SHADOW_STORE, en.shadow_store);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_push_byte();
		case ($urandom_range(0, 3))
			0: return OP_PUSH_RBX;
			1: return OP_PUSH_RBP;
			2: return OP_PUSH_RSI;
			default: return OP_PUSH_RDI;
		endcase
	endfunction

	// append one prologue pattern, near miss or filler
	task automatic add_code_fragment(ref logic [7:0] code[$]);
		logic [7:0] opcode_set [12];
		opcode_set = '{OP_PUSH_RBP, OP_REX_W, OP_MOV, OP_MODRM_RBP_RSP, OP_GRP1_IMM8,
			OP_MODRM_SUB_RSP, OP_GRP1_IMM32, OP_MODRM_SIB_RCX, OP_SIB_RSP, OP_PUSH_RBX,
			OP_PUSH_RSI, OP_PUSH_RDI};
		case ($urandom_range(0, 9))
			0, 1: begin
				code.insert(code.size(), OP_PUSH_RBP);
				code.insert(code.size(), OP_REX_W);
				code.insert(code.size(), OP_MOV);
				code.insert(code.size(), OP_MODRM_RBP_RSP);
			end
			2: begin
				code.insert(code.size(), OP_REX_W);
				code.insert(code.size(), OP_GRP1_IMM8);
				code.insert(code.size(), OP_MODRM_SUB_RSP);
				code.insert(code.size(), 8'($urandom));
			end
			3: begin
				code.insert(code.size(), OP_REX_W);
				code.insert(code.size(), OP_GRP1_IMM32);
				code.insert(code.size(), OP_MODRM_SUB_RSP);
				repeat (4) code.insert(code.size(), 8'($urandom));
			end
			4: begin
				code.insert(code.size(), OP_REX_W);
				code.insert(code.size(), OP_MOV);
				code.insert(code.size(), OP_MODRM_SIB_RCX);
				code.insert(code.size(), OP_SIB_RSP);
			end
			5: begin
				code.insert(code.size(), pick_push_byte());
				code.insert(code.size(), $urandom_range(0, 1) ? OP_REX_W : pick_push_byte());
			end
			6: begin
				code.insert(code.size(), OP_REX_W);
				code.insert(code.size(), opcode_set[$urandom_range(0, 11)]);
				code.insert(code.size(), 8'($urandom));
			end
			7, 8: code.insert(code.size(), opcode_set[$urandom_range(0, 11)]);
			default: code.insert(code.size(), 8'($urandom));
		endcase
	endtask

	// push frame at the top of the address space, aligned push pair on the wrap
	// to zero, sub rsp imm32 with its whole immediate inside the section
	task automatic test_pattern_set();
		logic [7:0] code[$];
		logic       known[$];
		code = {OP_PUSH_RBP, OP_REX_W, OP_MOV, OP_MODRM_RBP_RSP, OP_PUSH_RDI, OP_PUSH_RBX,
			8'h90, 8'h90, OP_REX_W, OP_GRP1_IMM32, OP_MODRM_SUB_RSP, 8'h00, 8'h01, 8'h00,
			8'hFF};
		send_section(code, known, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1, -1);
	endtask

	task automatic test_special_cases();
		logic [7:0] code[$];
		logic       known[$];
		// known first position, sub rsp imm8 as the second position settled at the end
		code = {OP_REX_W, OP_REX_W, OP_GRP1_IMM8, OP_MODRM_SUB_RSP, 8'h08, 8'h00};
		known = {1'b1};
		send_section(code, known, 64'h0000_0000_0000_1000, 1'b1, -1);
		// five-byte section: only position zero is scanned
		code = {OP_REX_W, OP_MOV, OP_MODRM_SIB_RCX, OP_SIB_RSP, 8'h00};
		known.delete();
		send_section(code, known, 64'h8000_0000_0000_0011, 1'b1, -1);
		// four-byte section never reports
		code = {OP_PUSH_RBP, OP_REX_W, OP_MOV, OP_MODRM_RBP_RSP};
		send_section(code, known, 64'h0000_0000_0000_0000, 1'b1, -1);
	endtask

	task automatic test_random_scan();
		cpbs_cfg_t   en;
		logic [7:0]  code[$];
		logic        known[$];
		logic [63:0] base;
		int          len;
		int          sent;
		int          known_pct;
		int          jump;
		for (int phase = 0; phase < 8; phase++) begin
			wait_scan_idle();
			if (phase == 0)
				en = '0;
			else if (phase == 1)
				en = '1;
			else
				en = 3'($urandom_range(0, 7));
			set_scan_enables(en);
			gaps_on = (phase % 4) != 0;
			rx_mode = rx_mode_e'(phase % 4);
			sent = 0;
			while (sent < 135) begin
				code.delete();
				known.delete();
				case ($urandom_range(0, 9))
					0: len = $urandom_range(1, 5);
					1: len = $urandom_range(30, 48);
					default: len = $urandom_range(6, 20);
				endcase
				while (code.size() < len) add_code_fragment(code);
				while (code.size() > len) void'(code.pop_back());
				known_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
				repeat (len) known.insert(known.size(), $urandom_range(0, 99) < known_pct);
				case ($urandom_range(0, 2))
					0: base = {$urandom, $urandom};
					1: base = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
					default: base = {$urandom, $urandom} & ~64'hF;
				endcase
				jump = ($urandom_range(0, 29) == 0) ? $urandom_range(0, len - 1) : -1;
				send_section(code, known, base, $urandom_range(0, 19) != 0, jump);
				sent += len;
			end
		end
	endtask

	initial begin
		clear_scan_window();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pattern_set();
		test_special_cases();
		test_random_scan();
		wait_scan_idle();
		if (prologue_expected.size() != 0) begin
			$display("%0t: %0d prologue addresses never came out, oldest expected %h",
				$time, prologue_expected.size(), prologue_expected[0]);
			fail_count++;
		end
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
